>>> hdl/spa_pkg.sv
// Shared types and constants for the sparse polynomial adder.
package spa_pkg;

  localparam int MAX_TERMS_DEF = 32;

  localparam int ACTION_W = 2;
  localparam int COEF_W   = 16;
  localparam int EXPON_W  = 16;
  localparam int SUM_W    = 17;

  localparam logic [ACTION_W-1:0] ACT_LOAD_FIRST  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_SECOND = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RUN         = 2'd2;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic [EXPON_W-1:0]       expon;
  } term_t;

  localparam int TERM_W = $bits(term_t);

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_coef;
    logic [EXPON_W-1:0]      sum_expon;
    logic                    last_term;
    logic                    empty_sum;
    logic                    overflow;
  } result_t;

endpackage

>>> hdl/spa_if.sv
// Request and result channel interfaces of the sparse polynomial adder.
interface spa_in_if import spa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ACTION_W-1:0]      action;
  logic signed [COEF_W-1:0] term_coef;
  logic [EXPON_W-1:0]       term_expon;

  modport source (output valid, action, term_coef, term_expon, input ready);
  modport sink (input valid, action, term_coef, term_expon, output ready);
endinterface

interface spa_out_if import spa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] sum_coef;
  logic [EXPON_W-1:0]      sum_expon;
  logic                    last_term;
  logic                    empty_sum;
  logic                    overflow;

  modport source (output valid, sum_coef, sum_expon, last_term, empty_sum, overflow,
                  input ready);
  modport sink (input valid, sum_coef, sum_expon, last_term, empty_sum, overflow,
                output ready);
endinterface

>>> hdl/spa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/spa_merge.sv
// Merge sequencer: walks both term lists through one compare and add unit.
module spa_merge import spa_pkg::*; #(
  parameter int MAX_TERMS = MAX_TERMS_DEF,
  localparam int CNT_W = $clog2(MAX_TERMS + 1),
  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CNT_W-1:0]  first_cnt,
  input  logic [CNT_W-1:0]  second_cnt,
  input  logic              dropped,
  output logic              busy,
  output logic [AW-1:0]     raddr_first,
  output logic [AW-1:0]     raddr_second,
  input  term_t             rdata_first,
  input  term_t             rdata_second,
  spa_out_if.source         out_ch
);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_MERGE = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [CNT_W-1:0] na_r, na_nxt, nb_r, nb_nxt;
  result_t          hold_r, hold_nxt;
  logic             hold_valid_r, hold_valid_nxt;
  result_t          out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic                    slot_free, a_left, b_left, finish, take_a, take_b, cand_valid;
  logic signed [SUM_W-1:0] pair_sum;
  result_t                 cand;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign a_left    = a_r < na_r;
  assign b_left    = b_r < nb_r;
  assign pair_sum  = SUM_W'(rdata_first.coef) + SUM_W'(rdata_second.coef);

  always_comb begin
    finish     = 1'b0;
    take_a     = 1'b0;
    take_b     = 1'b0;
    cand_valid = 1'b1;
    cand       = '{sum_coef: SUM_W'(rdata_first.coef), sum_expon: rdata_first.expon,
                   last_term: 1'b0, empty_sum: 1'b0, overflow: dropped};
    if (!a_left && !b_left) begin
      finish     = 1'b1;
      cand_valid = 1'b0;
    end else if (a_left && b_left) begin
      if (rdata_first.expon == rdata_second.expon) begin
        take_a        = 1'b1;
        take_b        = 1'b1;
        cand.sum_coef = pair_sum;
        cand_valid    = pair_sum != '0;
      end else if (rdata_first.expon > rdata_second.expon) begin
        take_a = 1'b1;
      end else begin
        take_b         = 1'b1;
        cand.sum_coef  = SUM_W'(rdata_second.coef);
        cand.sum_expon = rdata_second.expon;
      end
    end else if (a_left) begin
      take_a = 1'b1;
    end else begin
      take_b         = 1'b1;
      cand.sum_coef  = SUM_W'(rdata_second.coef);
      cand.sum_expon = rdata_second.expon;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    na_nxt         = na_r;
    nb_nxt         = nb_r;
    hold_nxt       = hold_r;
    hold_valid_nxt = hold_valid_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          na_nxt    = first_cnt;
          nb_nxt    = second_cnt;
          a_nxt     = '0;
          b_nxt     = '0;
          state_nxt = S_MERGE;
        end
      end
      S_MERGE: begin
        if (slot_free) begin
          if (finish) begin
            out_valid_nxt = 1'b1;
            if (hold_valid_r) begin
              out_nxt           = hold_r;
              out_nxt.last_term = 1'b1;
            end else begin
              out_nxt = '{sum_coef: '0, sum_expon: '0, last_term: 1'b1,
                          empty_sum: 1'b1, overflow: dropped};
            end
            hold_valid_nxt = 1'b0;
            a_nxt          = '0;
            b_nxt          = '0;
            state_nxt      = S_IDLE;
          end else begin
            if (take_a) begin
              a_nxt = a_r + CNT_W'(1);
            end
            if (take_b) begin
              b_nxt = b_r + CNT_W'(1);
            end
            if (cand_valid) begin
              if (hold_valid_r) begin
                out_nxt       = hold_r;
                out_valid_nxt = 1'b1;
              end
              hold_nxt       = cand;
              hold_valid_nxt = 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign raddr_first  = (a_nxt == CNT_W'(MAX_TERMS)) ? '0 : a_nxt[AW-1:0];
  assign raddr_second = (b_nxt == CNT_W'(MAX_TERMS)) ? '0 : b_nxt[AW-1:0];
  assign busy         = state_r == S_MERGE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      a_r          <= '0;
      b_r          <= '0;
      na_r         <= '0;
      nb_r         <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      a_r          <= a_nxt;
      b_r          <= b_nxt;
      na_r         <= na_nxt;
      nb_r         <= nb_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.sum_coef  = out_r.sum_coef;
  assign out_ch.sum_expon = out_r.sum_expon;
  assign out_ch.last_term = out_r.last_term;
  assign out_ch.empty_sum = out_r.empty_sum;
  assign out_ch.overflow  = out_r.overflow;

endmodule

>>> hdl/sparse_polynomial_adder.sv
// Top level of the sparse polynomial adder: term loading, list storage and merge.
// Usage:
//   in_ch carries one request per handshake: load a term of the first list,
//   load a term of the second list, or run the addition (code 3 is ignored).
//   Terms go in descending exponent order; loads past MAX_TERMS are dropped
//   and set a sticky overflow flag that every result reports until reset.
//   A load gives no result.
//   A run drops ready and walks both lists through one shared compare and
//   add unit, one merge step per cycle while the output is not stalled,
//   reading one entry of each list RAM per step and giving roughly one
//   result term per step. The final term carries last_term; a run whose
//   lists are empty or whose terms all cancel gives one item with
//   empty_sum and last_term set. A run empties both lists.
//   out_ch is driven from an output register; when the receiver stalls, the
//   merge holds in place and resumes with nothing lost.
//   Reset (rst_n low, synchronous) empties both lists and clears overflow.
module sparse_polynomial_adder import spa_pkg::*; #(
  parameter int MAX_TERMS = MAX_TERMS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  spa_in_if.sink    in_ch,
  spa_out_if.source out_ch
);

  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam int AW    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  logic [CNT_W-1:0] first_cnt_r, first_cnt_nxt, second_cnt_r, second_cnt_nxt;
  logic             dropped_r, dropped_nxt;
  logic             accept, busy, start;
  logic             we_first, we_second;
  logic [AW-1:0]    raddr_first, raddr_second;
  logic [TERM_W-1:0] rdata_first, rdata_second;
  term_t            wterm;

  assign in_ch.ready = !busy;
  assign accept      = in_ch.valid && in_ch.ready;
  assign wterm       = '{coef: in_ch.term_coef, expon: in_ch.term_expon};
  assign start       = accept && (in_ch.action == ACT_RUN);

  always_comb begin
    first_cnt_nxt  = first_cnt_r;
    second_cnt_nxt = second_cnt_r;
    dropped_nxt    = dropped_r;
    we_first       = 1'b0;
    we_second      = 1'b0;
    if (accept) begin
      case (in_ch.action)
        ACT_LOAD_FIRST: begin
          if (first_cnt_r < CNT_W'(MAX_TERMS)) begin
            we_first      = 1'b1;
            first_cnt_nxt = first_cnt_r + CNT_W'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
        end
        ACT_LOAD_SECOND: begin
          if (second_cnt_r < CNT_W'(MAX_TERMS)) begin
            we_second      = 1'b1;
            second_cnt_nxt = second_cnt_r + CNT_W'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
        end
        ACT_RUN: begin
          first_cnt_nxt  = '0;
          second_cnt_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_cnt_r  <= '0;
      second_cnt_r <= '0;
      dropped_r    <= 1'b0;
    end else begin
      first_cnt_r  <= first_cnt_nxt;
      second_cnt_r <= second_cnt_nxt;
      dropped_r    <= dropped_nxt;
    end
  end

  spa_ram #(
    .WIDTH(TERM_W),
    .DEPTH(MAX_TERMS)
  ) u_first_ram (
    .clk  (clk),
    .we   (we_first),
    .waddr(first_cnt_r[AW-1:0]),
    .wdata(wterm),
    .raddr(raddr_first),
    .rdata(rdata_first)
  );

  spa_ram #(
    .WIDTH(TERM_W),
    .DEPTH(MAX_TERMS)
  ) u_second_ram (
    .clk  (clk),
    .we   (we_second),
    .waddr(second_cnt_r[AW-1:0]),
    .wdata(wterm),
    .raddr(raddr_second),
    .rdata(rdata_second)
  );

  spa_merge #(
    .MAX_TERMS(MAX_TERMS)
  ) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .first_cnt   (first_cnt_r),
    .second_cnt  (second_cnt_r),
    .dropped     (dropped_r),
    .busy        (busy),
    .raddr_first (raddr_first),
    .raddr_second(raddr_second),
    .rdata_first (term_t'(rdata_first)),
    .rdata_second(term_t'(rdata_second)),
    .out_ch      (out_ch)
  );

endmodule

>>> tb/sparse_polynomial_adder_tb.sv
// Self-checking testbench for the sparse polynomial adder: directed table, random merges, stalls.
`timescale 1ns / 100ps

module sparse_polynomial_adder_tb;
  import spa_pkg::*;

  localparam int LIST_DEPTH = MAX_TERMS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_GOAL = 250;
  localparam int TOTAL_GOAL = 380;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam logic [ACTION_W-1:0] ACT_IGNORED = 2'd3;

  typedef struct {
    logic [ACTION_W-1:0]      act;
    logic signed [COEF_W-1:0] coef;
    logic [EXPON_W-1:0]       expon;
    bit                       typed;
    result_t                  want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  spa_in_if in_ch ();
  spa_out_if out_ch ();

  sparse_polynomial_adder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [COEF_W-1:0] first_coef [LIST_DEPTH];
  logic [EXPON_W-1:0]       first_expon [LIST_DEPTH];
  logic signed [COEF_W-1:0] second_coef [LIST_DEPTH];
  logic [EXPON_W-1:0]       second_expon [LIST_DEPTH];
  int                       first_len;
  int                       second_len;
  bit                       lists_dropped;

  result_t merged_terms [$];
  result_t pending_terms [$];

  int err_count;
  int req_count;
  int run_count;
  int terms_checked;
  int longest_run;
  int cycle_count;
  int idle_pct;
  int stall_pct;
  int stall_left;
  bit long_hold;
  bit long_hold_done;
  int pct_choice [4] = '{0, 5, 20, 50};

  stim_row_t directed_rows [24] = '{
    '{ACT_RUN,         16'h0000, 16'h0000, 1'b1, '{17'h00000, 16'h0000, 1'b1, 1'b1, 1'b0}},
    '{ACT_LOAD_FIRST,  16'h8000, 16'hFFFF, 1'b0, '0},
    '{ACT_RUN,         16'h0000, 16'h0000, 1'b1, '{17'h18000, 16'hFFFF, 1'b1, 1'b0, 1'b0}},
    '{ACT_LOAD_SECOND, 16'h7FFF, 16'h0000, 1'b0, '0},
    '{ACT_RUN,         16'h0000, 16'h0000, 1'b1, '{17'h07FFF, 16'h0000, 1'b1, 1'b0, 1'b0}},
    '{ACT_LOAD_FIRST,  16'h0005, 16'd100,  1'b0, '0},
    '{ACT_LOAD_SECOND, 16'hFFFB, 16'd100,  1'b0, '0},
    '{ACT_RUN,         16'h0000, 16'h0000, 1'b1, '{17'h00000, 16'h0000, 1'b1, 1'b1, 1'b0}},
    '{ACT_LOAD_FIRST,  16'h8000, 16'd7,    1'b0, '0},
    '{ACT_LOAD_SECOND, 16'h8000, 16'd7,    1'b0, '0},
    '{ACT_RUN,         16'h0000, 16'h0000, 1'b1, '{17'h10000, 16'd7, 1'b1, 1'b0, 1'b0}},
    '{ACT_LOAD_FIRST,  16'h0000, 16'd9,    1'b0, '0},
    '{ACT_RUN,         16'h0000, 16'h0000, 1'b1, '{17'h00000, 16'd9, 1'b1, 1'b0, 1'b0}},
    '{ACT_IGNORED,     16'h1234, 16'hABCD, 1'b0, '0},
    '{ACT_RUN,         16'h0000, 16'h0000, 1'b1, '{17'h00000, 16'h0000, 1'b1, 1'b1, 1'b0}},
    '{ACT_LOAD_FIRST,  16'h0003, 16'd50,   1'b0, '0},
    '{ACT_LOAD_FIRST,  16'h0004, 16'd50,   1'b0, '0},
    '{ACT_LOAD_FIRST,  16'h0001, 16'd60,   1'b0, '0},
    '{ACT_LOAD_SECOND, 16'h0007, 16'd50,   1'b0, '0},
    '{ACT_LOAD_SECOND, 16'h0002, 16'd10,   1'b0, '0},
    '{ACT_RUN,         16'h0000, 16'h0000, 1'b0, '0},
    '{ACT_LOAD_FIRST,  16'h7FFF, 16'hFFFF, 1'b0, '0},
    '{ACT_LOAD_SECOND, 16'h7FFF, 16'hFFFF, 1'b0, '0},
    '{ACT_RUN,         16'h0000, 16'h0000, 1'b1, '{17'h0FFFE, 16'hFFFF, 1'b1, 1'b0, 1'b0}}
  };

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  function automatic void add_term(input int coef, input logic [EXPON_W-1:0] expon,
                                   input bit empty);
    result_t t;
    t.sum_coef = coef[SUM_W-1:0];
    t.sum_expon = expon;
    t.last_term = 1'b0;
    t.empty_sum = empty;
    t.overflow = lists_dropped;
    merged_terms.push_back(t);
  endfunction

  task automatic apply_request(input logic [ACTION_W-1:0] act,
                               input logic signed [COEF_W-1:0] coef,
                               input logic [EXPON_W-1:0] expon);
    int ia;
    int ib;
    int s;
    merged_terms.delete();
    case (act)
      ACT_LOAD_FIRST: begin
        if (first_len < LIST_DEPTH) begin
          first_coef[first_len] = coef;
          first_expon[first_len] = expon;
          first_len++;
        end else begin
          lists_dropped = 1'b1;
        end
      end
      ACT_LOAD_SECOND: begin
        if (second_len < LIST_DEPTH) begin
          second_coef[second_len] = coef;
          second_expon[second_len] = expon;
          second_len++;
        end else begin
          lists_dropped = 1'b1;
        end
      end
      ACT_RUN: begin
        ia = 0;
        ib = 0;
        while (ia < first_len && ib < second_len) begin
          if (first_expon[ia] == second_expon[ib]) begin
            s = int'(first_coef[ia]) + int'(second_coef[ib]);
            if (s != 0) add_term(s, first_expon[ia], 1'b0);
            ia++;
            ib++;
          end else if (first_expon[ia] > second_expon[ib]) begin
            add_term(int'(first_coef[ia]), first_expon[ia], 1'b0);
            ia++;
          end else begin
            add_term(int'(second_coef[ib]), second_expon[ib], 1'b0);
            ib++;
          end
        end
        for (; ia < first_len; ia++) add_term(int'(first_coef[ia]), first_expon[ia], 1'b0);
        for (; ib < second_len; ib++) add_term(int'(second_coef[ib]), second_expon[ib], 1'b0);
        if (merged_terms.size() == 0) add_term(0, '0, 1'b1);
        merged_terms[merged_terms.size()-1].last_term = 1'b1;
        if (merged_terms.size() > longest_run) longest_run = merged_terms.size();
        first_len = 0;
        second_len = 0;
        run_count++;
      end
      default: ;
    endcase
  endtask

  task automatic send_request(input logic [ACTION_W-1:0] act,
                              input logic signed [COEF_W-1:0] coef,
                              input logic [EXPON_W-1:0] expon,
                              input bit typed = 1'b0, input result_t want = '0);
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.term_coef <= coef;
    in_ch.term_expon <= expon;
    do @(posedge clk); while (!in_ch.ready);
    apply_request(act, coef, expon);
    if (typed) begin
      pending_terms.push_back(want);
    end else begin
      foreach (merged_terms[i]) pending_terms.push_back(merged_terms[i]);
    end
    if (act != ACT_IGNORED) req_count++;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.action <= ACTION_W'($urandom);
      in_ch.term_coef <= COEF_W'($urandom);
      in_ch.term_expon <= EXPON_W'($urandom);
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic send_merge_case(input int pool_len);
    int expo_pool [$];
    term_t list_a [$];
    term_t list_b [$];
    term_t t;
    term_t u;
    bit narrow;
    int pick;
    narrow = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < pool_len; i++) begin
      expo_pool.push_back(narrow ? $urandom_range(0, 31) : $urandom_range(0, 65535));
    end
    expo_pool.rsort();
    foreach (expo_pool[i]) begin
      pick = $urandom_range(0, 9);
      t.coef = COEF_W'($urandom);
      t.expon = EXPON_W'(expo_pool[i]);
      if (pick < 4) begin
        list_a.push_back(t);
      end else if (pick < 7) begin
        list_b.push_back(t);
      end else begin
        u.expon = t.expon;
        u.coef = ($urandom_range(0, 2) == 0) ? -t.coef : COEF_W'($urandom);
        list_a.push_back(t);
        list_b.push_back(u);
      end
    end
    while (list_a.size() + list_b.size() > 0) begin
      if (list_b.size() == 0 || (list_a.size() > 0 && $urandom_range(0, 1) == 1)) begin
        t = list_a.pop_front();
        send_request(ACT_LOAD_FIRST, t.coef, t.expon);
      end else begin
        t = list_b.pop_front();
        send_request(ACT_LOAD_SECOND, t.coef, t.expon);
      end
    end
    send_request(ACT_RUN, COEF_W'($urandom), EXPON_W'($urandom));
  endtask

  task automatic send_noise_case();
    int n;
    n = $urandom_range(1, 10);
    repeat (n) send_request(ACTION_W'($urandom), COEF_W'($urandom), EXPON_W'($urandom));
    send_request(ACT_RUN, COEF_W'($urandom), EXPON_W'($urandom));
  endtask

  task automatic send_random_case();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      send_noise_case();
    end else if (r < 17) begin
      send_merge_case($urandom_range(0, 8));
    end else if (r < 19) begin
      send_merge_case($urandom_range(9, 20));
    end else begin
      send_merge_case($urandom_range(21, 32));
    end
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (long_hold && !long_hold_done) begin
        long_hold_done = 1'b1;
        stall_left = LONG_HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 16);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_terms.size() == 0) begin
        report_mismatch($sformatf("unexpected result coef=%0d expon=%0d last=%b empty=%b",
                                  out_ch.sum_coef, out_ch.sum_expon, out_ch.last_term,
                                  out_ch.empty_sum));
      end else begin
        want = pending_terms.pop_front();
        terms_checked++;
        if (out_ch.sum_coef !== want.sum_coef)
          report_mismatch($sformatf("sum_coef %0d, want %0d", out_ch.sum_coef, want.sum_coef));
        if (out_ch.sum_expon !== want.sum_expon)
          report_mismatch($sformatf("sum_expon %0d, want %0d", out_ch.sum_expon,
                                    want.sum_expon));
        if (out_ch.last_term !== want.last_term)
          report_mismatch($sformatf("last_term %b, want %b", out_ch.last_term, want.last_term));
        if (out_ch.empty_sum !== want.empty_sum)
          report_mismatch($sformatf("empty_sum %b, want %b", out_ch.empty_sum, want.empty_sum));
        if (out_ch.overflow !== want.overflow)
          report_mismatch($sformatf("overflow %b, want %b", out_ch.overflow, want.overflow));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_terms.size());
    $display("FAIL sparse_polynomial_adder");
    $finish;
  end

  initial begin
    int seq;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.action <= ACT_IGNORED;
    in_ch.term_coef <= '0;
    in_ch.term_expon <= '0;
    idle_pct = 0;
    stall_pct <= 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    stall_pct <= 20;
    idle_pct = 20;
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].act, directed_rows[i].coef, directed_rows[i].expon,
                   directed_rows[i].typed, directed_rows[i].want);
    end

    seq = 0;
    while (req_count < RANDOM_GOAL) begin
      if (seq % 6 == 0) begin
        idle_pct = pct_choice[$urandom_range(0, 3)];
        stall_pct <= pct_choice[$urandom_range(0, 3)];
      end
      if (seq == 12) begin
        in_ch.valid <= 1'b0;
        while (pending_terms.size() != 0) @(posedge clk);
      end
      if (seq == 20) begin
        idle_pct = 0;
        long_hold <= 1'b1;
        send_merge_case(32);
      end else begin
        send_random_case();
      end
      seq++;
    end

    // fill both lists past capacity; no shared exponents, so every stored term comes out
    for (int i = 0; i < LIST_DEPTH + 2; i++) begin
      send_request(ACT_LOAD_FIRST, COEF_W'($urandom), 16'(64000 - 2 * i * 900));
      send_request(ACT_LOAD_SECOND, COEF_W'($urandom), 16'(64000 - (2 * i + 1) * 900));
    end
    send_request(ACT_RUN, COEF_W'($urandom), EXPON_W'($urandom));

    idle_pct = 0;
    stall_pct <= 0;
    while (req_count < TOTAL_GOAL) send_random_case();

    in_ch.valid <= 1'b0;
    while (pending_terms.size() != 0) @(posedge clk);
    repeat (2 * LIST_DEPTH + 8) @(posedge clk);

    $display("covered %0d requests over %0d runs, %0d result terms checked",
             req_count, run_count, terms_checked);
    $display("longest merge %0d terms, list overflow reached: %0b", longest_run, lists_dropped);
    if (err_count == 0) begin
      $display("PASS sparse_polynomial_adder");
    end else begin
      $display("%0d mismatches", err_count);
      $display("FAIL sparse_polynomial_adder");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/spa_pkg.sv
hdl/spa_if.sv
hdl/spa_ram.sv
hdl/spa_merge.sv
hdl/sparse_polynomial_adder.sv
tb/sparse_polynomial_adder_tb.sv
